/* rtl/core/fhar_pkg.sv */
// ----------------------------------------------------------------------------
// Four-hit angle ratio check package
// Shared widths, constants and types for the angle and ratio pipeline.
// ----------------------------------------------------------------------------
package fhar_pkg;

  localparam int COORD_BITS      = 24;
  localparam int ANGLE_FRAC_BITS = 16;

  localparam int NUM_COORDS    = 12;
  localparam int IN_BITS       = NUM_COORDS * COORD_BITS;
  localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS      = 33;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int MAG_BITS   = SUM_BITS - 1;
  localparam int SHIFT_BITS = $clog2(MAG_BITS);
  localparam int NORM_BITS  = 30;
  localparam int SQ_BITS    = 2 * NORM_BITS;
  localparam int SQSUM_BITS = SQ_BITS + 2;
  localparam int REM_BITS   = SQSUM_BITS + 1;
  localparam int ROOT_BITS  = NORM_BITS + 1;
  localparam int SQRT_STEPS = ROOT_BITS;
  localparam int LZ_BITS    = $clog2(ROOT_BITS);

  localparam int CORDIC_STEPS = 31;
  localparam int CX_BITS      = 36;
  localparam int CZ_BITS      = 34;
  localparam int ZU_BITS      = CZ_BITS - 1;
  localparam int ROUND_SHIFT  = 30 - ANGLE_FRAC_BITS;

  localparam int ANGLE_BITS = ANGLE_FRAC_BITS + 2;
  localparam int NUM_BITS   = ANGLE_BITS + ANGLE_FRAC_BITS;
  localparam int RATIO_BITS = 31;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic signed [CZ_BITS-1:0] Q30_PI      = CZ_BITS'(64'd3373259426);
  localparam logic signed [CZ_BITS-1:0] Q30_HALF_PI = CZ_BITS'(64'd1686629713);
  localparam logic [ZU_BITS-1:0] ROUND_HALF = ZU_BITS'(1) << (ROUND_SHIFT - 1);
  localparam logic [RATIO_BITS-1:0] RATIO_SAT = '1;

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0
  };

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RATIO_MIN = 8'd0,
    CFG_RATIO_MAX = 8'd1
  } cfg_index_t;

  typedef logic signed [DIFF_BITS-1:0] diff_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } vec_t;

  function automatic logic [MAG_BITS-1:0] mag_of(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] n;
    n = -v;
    return v[SUM_BITS-1] ? MAG_BITS'(n) : MAG_BITS'(v);
  endfunction

endpackage

/* rtl/core/fhar_angle.sv */
// ----------------------------------------------------------------------------
// Angle between two vectors
// Cross and dot products, common scaling, pipelined square root, then a
// pipelined vectoring CORDIC giving atan2(|p x q|, p . q) in fixed point.
// ----------------------------------------------------------------------------
module fhar_angle (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  fhar_pkg::vec_t                      p,
  input  fhar_pkg::vec_t                      q,
  output logic                                out_valid,
  output logic [fhar_pkg::ANGLE_BITS-1:0]     angle
);

  localparam int PB = fhar_pkg::PROD_BITS;
  localparam int SB = fhar_pkg::SUM_BITS;
  localparam int MB = fhar_pkg::MAG_BITS;
  localparam int NB = fhar_pkg::NORM_BITS;
  localparam int RB = fhar_pkg::ROOT_BITS;
  localparam int QB = fhar_pkg::REM_BITS;
  localparam int XB = fhar_pkg::CX_BITS;
  localparam int ZB = fhar_pkg::CZ_BITS;
  localparam int NSQ = fhar_pkg::SQRT_STEPS;
  localparam int NCO = fhar_pkg::CORDIC_STEPS;

  logic [5:0] vf;
  logic [NSQ:0] vs;
  logic [1:0] vn;
  logic [NCO:0] vc;

  logic signed [PB-1:0] pr [9];
  logic signed [SB-1:0] c0, c1, c2, dt;
  logic [MB-1:0] m0, m1, m2, md;
  logic d_neg3;
  logic [fhar_pkg::SHIFT_BITS-1:0] sh;
  logic [NB-1:0] cm0, cm1, cm2, dm;
  logic d_neg4;
  logic [fhar_pkg::SQ_BITS-1:0] sq0, sq1, sq2;
  logic signed [RB-1:0] x5;

  logic [QB-1:0] rem [NSQ];
  logic [RB-1:0] root [NSQ+1];
  logic signed [RB-1:0] sx [NSQ+1];

  logic signed [RB-1:0] nx;
  logic [RB-1:0] ny;
  logic [fhar_pkg::LZ_BITS-1:0] nk;

  logic signed [XB-1:0] cx [NCO];
  logic signed [XB-1:0] cy [NCO];
  logic signed [ZB-1:0] cz [NCO+1];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= '0;
      vs[NSQ:1] <= '0;
      vn <= '0;
      vc[NCO:1] <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vf <= {vf[4:0], in_valid};
      for (int i = 0; i < NSQ; i++) begin
        vs[i+1] <= vs[i];
      end
      vn <= {vn[0], vs[NSQ]};
      for (int j = 0; j < NCO; j++) begin
        vc[j+1] <= vc[j];
      end
      out_valid <= vc[NCO];
    end
  end

  assign vs[0] = vf[5];
  assign vc[0] = vn[1];

  // Front end: products, sums, common scaling, squares.
  always_ff @(posedge clk) begin
    logic [MB-1:0] orv;
    logic [fhar_pkg::SHIFT_BITS-1:0] s;
    logic [MB-1:0] a0, a1, a2, ad;
    if (en) begin
      pr[0] <= PB'(p.y) * PB'(q.z);
      pr[1] <= PB'(p.z) * PB'(q.y);
      pr[2] <= PB'(p.z) * PB'(q.x);
      pr[3] <= PB'(p.x) * PB'(q.z);
      pr[4] <= PB'(p.x) * PB'(q.y);
      pr[5] <= PB'(p.y) * PB'(q.x);
      pr[6] <= PB'(p.x) * PB'(q.x);
      pr[7] <= PB'(p.y) * PB'(q.y);
      pr[8] <= PB'(p.z) * PB'(q.z);

      c0 <= SB'(pr[0]) - SB'(pr[1]);
      c1 <= SB'(pr[2]) - SB'(pr[3]);
      c2 <= SB'(pr[4]) - SB'(pr[5]);
      dt <= SB'(pr[6]) + SB'(pr[7]) + SB'(pr[8]);

      a0 = fhar_pkg::mag_of(c0);
      a1 = fhar_pkg::mag_of(c1);
      a2 = fhar_pkg::mag_of(c2);
      ad = fhar_pkg::mag_of(dt);
      orv = a0 | a1 | a2 | ad;
      s = '0;
      for (int i = NB; i < MB; i++) begin
        if (orv[i]) begin
          s = fhar_pkg::SHIFT_BITS'(i - (NB - 1));
        end
      end
      m0 <= a0;
      m1 <= a1;
      m2 <= a2;
      md <= ad;
      d_neg3 <= dt[SB-1];
      sh <= s;

      cm0 <= NB'(m0 >> sh);
      cm1 <= NB'(m1 >> sh);
      cm2 <= NB'(m2 >> sh);
      dm <= NB'(md >> sh);
      d_neg4 <= d_neg3;

      sq0 <= fhar_pkg::SQ_BITS'(cm0) * fhar_pkg::SQ_BITS'(cm0);
      sq1 <= fhar_pkg::SQ_BITS'(cm1) * fhar_pkg::SQ_BITS'(cm1);
      sq2 <= fhar_pkg::SQ_BITS'(cm2) * fhar_pkg::SQ_BITS'(cm2);
      x5 <= d_neg4 ? -$signed({1'b0, dm}) : $signed({1'b0, dm});

      rem[0] <= QB'(sq0) + QB'(sq1) + QB'(sq2);
      sx[0] <= x5;
    end
  end

  assign root[0] = '0;

  // Square root, one result bit per stage.
  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    localparam int B = NSQ - 1 - i;
    logic [QB-1:0] trial;
    logic fits;
    assign trial = (QB'(root[i]) << (B + 1)) + (QB'(1) << (2 * B));
    assign fits = rem[i] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        root[i+1] <= fits ? (root[i] | (RB'(1) << B)) : root[i];
        sx[i+1] <= sx[i];
      end
    end
    if (i < NSQ - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= fits ? rem[i] - trial : rem[i];
        end
      end
    end
  end

  // Normalize the (dot, |cross|) pair and fold the left half plane.
  always_ff @(posedge clk) begin
    logic [RB-1:0] ax, m;
    logic [fhar_pkg::LZ_BITS-1:0] k;
    logic signed [XB-1:0] xs, ys;
    if (en) begin
      ax = sx[NSQ][RB-1] ? RB'(-sx[NSQ]) : RB'(sx[NSQ]);
      m = (ax > root[NSQ]) ? ax : root[NSQ];
      k = '0;
      for (int i = 0; i < RB; i++) begin
        if (m[i]) begin
          k = fhar_pkg::LZ_BITS'(RB - 1 - i);
        end
      end
      nx <= sx[NSQ];
      ny <= root[NSQ];
      nk <= k;

      xs = XB'(nx) <<< nk;
      ys = $signed(XB'(ny)) <<< nk;
      if (xs < 0) begin
        cx[0] <= ys;
        cy[0] <= -xs;
        cz[0] <= fhar_pkg::Q30_HALF_PI;
      end else begin
        cx[0] <= xs;
        cy[0] <= ys;
        cz[0] <= '0;
      end
    end
  end

  // Vectoring CORDIC, one iteration per stage.
  for (genvar j = 0; j < NCO; j++) begin : g_cordic
    logic signed [XB-1:0] dx, dy;
    logic signed [ZB-1:0] at;
    assign dx = cx[j] >>> j;
    assign dy = cy[j] >>> j;
    assign at = ZB'(fhar_pkg::ATAN_TAB[j]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[j] > 0) begin
          cz[j+1] <= cz[j] + at;
        end else if (cy[j] < 0) begin
          cz[j+1] <= cz[j] - at;
        end else begin
          cz[j+1] <= cz[j];
        end
      end
    end
    if (j < NCO - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          if (cy[j] > 0) begin
            cx[j+1] <= cx[j] + dy;
            cy[j+1] <= cy[j] - dx;
          end else if (cy[j] < 0) begin
            cx[j+1] <= cx[j] - dy;
            cy[j+1] <= cy[j] + dx;
          end else begin
            cx[j+1] <= cx[j];
            cy[j+1] <= cy[j];
          end
        end
      end
    end
  end

  // Clamp to [0, pi] and round half up.
  always_ff @(posedge clk) begin
    logic signed [ZB-1:0] zc;
    logic [fhar_pkg::ZU_BITS-1:0] zr;
    if (en) begin
      if (cz[NCO] < 0) begin
        zc = '0;
      end else if (cz[NCO] > fhar_pkg::Q30_PI) begin
        zc = fhar_pkg::Q30_PI;
      end else begin
        zc = cz[NCO];
      end
      zr = fhar_pkg::ZU_BITS'(zc) + fhar_pkg::ROUND_HALF;
      angle <= fhar_pkg::ANGLE_BITS'(zr >> fhar_pkg::ROUND_SHIFT);
    end
  end

endmodule

/* rtl/core/fhar_div.sv */
// ----------------------------------------------------------------------------
// Angle ratio divider
// Restoring division of the first angle, scaled up, by the second angle,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module fhar_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [fhar_pkg::ANGLE_BITS-1:0]     dividend,
  input  logic [fhar_pkg::ANGLE_BITS-1:0]     divisor,
  output logic                                out_valid,
  output logic [fhar_pkg::NUM_BITS-1:0]       quotient,
  output logic                                undefined
);

  localparam int AB = fhar_pkg::ANGLE_BITS;
  localparam int NB = fhar_pkg::NUM_BITS;

  logic [NB:0] vd;
  logic [NB:0] uf;
  logic [AB-1:0] pr [NB];
  logic [NB-1:0] nm [NB];
  logic [AB-1:0] dd [NB];
  logic [NB-1:0] qq [NB+1];

  assign vd[0] = in_valid;
  assign uf[0] = (dividend == '0) && (divisor == '0);
  assign pr[0] = '0;
  assign nm[0] = NB'(dividend) << fhar_pkg::ANGLE_FRAC_BITS;
  assign dd[0] = divisor;
  assign qq[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[NB:1] <= '0;
    end else if (en) begin
      vd[NB:1] <= vd[NB-1:0];
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_step
    logic [AB:0] r_sh;
    logic ge;
    assign r_sh = {pr[i], nm[i][NB-1]};
    assign ge = r_sh >= {1'b0, dd[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        qq[i+1] <= {qq[i][NB-2:0], ge};
        uf[i+1] <= uf[i];
      end
    end
    if (i < NB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          pr[i+1] <= ge ? AB'(r_sh - {1'b0, dd[i]}) : AB'(r_sh);
          nm[i+1] <= nm[i] << 1;
          dd[i+1] <= dd[i];
        end
      end
    end
  end

  assign out_valid = vd[NB];
  assign quotient = qq[NB];
  assign undefined = uf[NB];

endmodule

/* rtl/core/four_hit_angle_ratio_check.sv */
// ----------------------------------------------------------------------------
// Four-hit angle ratio check
// Angles between consecutive hit segments, their ratio and a window check.
// ----------------------------------------------------------------------------
// From an accepted item to its result the pipeline has one difference
// stage, 71 stages per angle unit, 34 divider stages and one output stage.
// Throughput is one item per cycle; a stalled output freezes the whole pipeline.
// Synchronous reset empties the pipeline and loads ratio_min = 0 and
// ratio_max = 2^31-1.
module four_hit_angle_ratio_check (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // point_a_x, point_a_y, point_a_z, point_b_x, ..., point_d_z
  input  logic [fhar_pkg::IN_TDATA_BITS-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // compatible, angle_ratio, ratio_undefined, zero fill
  output logic [fhar_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fhar_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [fhar_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int CB = fhar_pkg::COORD_BITS;
  localparam int DB = fhar_pkg::DIFF_BITS;

  logic en;
  logic signed [31:0] ratio_min, ratio_max;
  logic signed [CB-1:0] pt [fhar_pkg::NUM_COORDS];
  fhar_pkg::vec_t u, v, w;
  logic v_diff;
  logic a0_valid, a1_valid;
  logic [fhar_pkg::ANGLE_BITS-1:0] a0, a1;
  logic d_valid, d_undef;
  logic [fhar_pkg::NUM_BITS-1:0] d_quot;
  logic out_valid, out_compat, out_undef;
  logic [fhar_pkg::RATIO_BITS-1:0] out_ratio;

  assign en = !out_valid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_min <= '0;
      ratio_max <= 32'sh7FFFFFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        fhar_pkg::CFG_RATIO_MIN: ratio_min <= $signed(cfg_data);
        fhar_pkg::CFG_RATIO_MAX: ratio_max <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < fhar_pkg::NUM_COORDS; k++) begin : g_unpack
    assign pt[k] = $signed(s_tdata[k*CB +: CB]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_diff <= 1'b0;
    end else if (en) begin
      v_diff <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u.x <= DB'(pt[3]) - DB'(pt[0]);
      u.y <= DB'(pt[4]) - DB'(pt[1]);
      u.z <= DB'(pt[5]) - DB'(pt[2]);
      v.x <= DB'(pt[6]) - DB'(pt[3]);
      v.y <= DB'(pt[7]) - DB'(pt[4]);
      v.z <= DB'(pt[8]) - DB'(pt[5]);
      w.x <= DB'(pt[9]) - DB'(pt[6]);
      w.y <= DB'(pt[10]) - DB'(pt[7]);
      w.z <= DB'(pt[11]) - DB'(pt[8]);
    end
  end

  fhar_angle u_angle_first (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_diff),
    .p         (u),
    .q         (v),
    .out_valid (a0_valid),
    .angle     (a0)
  );

  fhar_angle u_angle_second (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_diff),
    .p         (v),
    .q         (w),
    .out_valid (a1_valid),
    .angle     (a1)
  );

  fhar_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a0_valid && a1_valid),
    .dividend  (a0),
    .divisor   (a1),
    .out_valid (d_valid),
    .quotient  (d_quot),
    .undefined (d_undef)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [fhar_pkg::RATIO_BITS-1:0] r;
    logic signed [31:0] rs;
    if (en) begin
      if (d_undef) begin
        r = '0;
      end else if (64'(d_quot) > 64'(fhar_pkg::RATIO_SAT)) begin
        r = fhar_pkg::RATIO_SAT;
      end else begin
        r = fhar_pkg::RATIO_BITS'(d_quot);
      end
      rs = $signed({1'b0, r});
      out_ratio <= r;
      out_undef <= d_undef;
      out_compat <= d_undef || ((rs >= ratio_min) && (rs <= ratio_max));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {(fhar_pkg::OUT_TDATA_BITS - fhar_pkg::OUT_BITS)'(0),
                    out_undef, out_ratio, out_compat};

endmodule

/* rtl/core/fhar_check.sv */
// ----------------------------------------------------------------------------
// Four-hit angle ratio check port checker
// Assertions on the stream ports of the top level, bound to it.
// ----------------------------------------------------------------------------
module fhar_check (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tready,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [fhar_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);

  // A result that waits keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("waiting result changed");

  // The pipeline takes input exactly when its output register can move.
  a_ready: assert property (@(posedge clk)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output state");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  // An undefined ratio passes and reads as zero.
  a_undef: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[0] && (m_tdata[31:1] == '0))
    else $error("undefined ratio not passed as zero");

endmodule

bind four_hit_angle_ratio_check fhar_check u_fhar_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* sim/fhar_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-hit angle ratio checker
// Watches the item, result and register channels of the block, predicts the
// angle ratio and window verdict for every accepted item, and compares each
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fhar_checker
  import fhar_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [OUT_TDATA_BITS-1:0] m_tdata,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        errors,
  output int                        pending,
  output int                        results,
  output int                        undef_seen,
  output int                        compat_seen
);

  typedef longint vec3_t [3];

  typedef struct {
    logic                  compat;
    logic [RATIO_BITS-1:0] ratio;
    logic                  undef;
  } ratio_result_t;

  localparam longint CZ_PI   = 64'd3373259426;
  localparam longint CZ_HALF = 64'd1686629713;

  ratio_result_t expected_q[$];
  longint        win_min;
  longint        win_max;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint shr_mag(longint v, int s);
    longint unsigned m;
    m = mag(v) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Angle between p and q, Q30 CORDIC result rounded to ANGLE_FRAC_BITS.
  function automatic longint unsigned angle_q(vec3_t p, vec3_t q);
    longint c [3];
    longint d, x, y, z, t, dx, dy;
    longint unsigned m, sq;
    int s;
    c[0] = p[1] * q[2] - p[2] * q[1];
    c[1] = p[2] * q[0] - p[0] * q[2];
    c[2] = p[0] * q[1] - p[1] * q[0];
    d = p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    m = mag(d);
    for (int i = 0; i < 3; i++) if (mag(c[i]) > m) m = mag(c[i]);
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) c[i] = shr_mag(c[i], s);
    d = shr_mag(d, s);
    sq = mag(c[0]) * mag(c[0]) + mag(c[1]) * mag(c[1]) + mag(c[2]) * mag(c[2]);
    y = longint'(int_sqrt(sq));
    x = d;
    m = mag(x) > y ? mag(x) : y;
    if (m == 0) return 0;
    while (m < (64'd1 << 30)) begin
      x = x * 2;
      y = y * 2;
      m = m << 1;
    end
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = CZ_HALF;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x = x + dy;
        y = y - dx;
        z = z + longint'(ATAN_TAB[i]);
      end else if (y < 0) begin
        x = x - dy;
        y = y + dx;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        break;
      end
    end
    if (z < 0) z = 0;
    if (z > CZ_PI) z = CZ_PI;
    return (longint'(z) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
  endfunction

  // Differences never reach 2^25 at this coordinate width, so the
  // per-vector prescale is a no-op and is left out.
  function automatic ratio_result_t predict_ratio(logic [IN_TDATA_BITS-1:0] d);
    longint pt [4][3];
    vec3_t u, v, w;
    longint unsigned a1, a2, r;
    ratio_result_t res;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++)
        pt[i][k] = longint'($signed(d[(i*3+k)*COORD_BITS +: COORD_BITS]));
    for (int k = 0; k < 3; k++) begin
      u[k] = pt[1][k] - pt[0][k];
      v[k] = pt[2][k] - pt[1][k];
      w[k] = pt[3][k] - pt[2][k];
    end
    a1 = angle_q(u, v);
    a2 = angle_q(v, w);
    r = 0;
    res.undef = 1'b0;
    if (a2 == 0) begin
      if (a1 == 0) res.undef = 1'b1;
      else r = 64'h7FFF_FFFF;
    end else begin
      r = (a1 << ANGLE_FRAC_BITS) / a2;
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    end
    res.ratio  = r[RATIO_BITS-1:0];
    res.compat = res.undef || (longint'(r) <= win_max && longint'(r) >= win_min);
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    ratio_result_t exp_r;
    ratio_result_t got;
    if (rst) begin
      win_min = 0;
      win_max = 64'sd2147483647;
      expected_q.delete();
      errors      <= 0;
      results     <= 0;
      undef_seen  <= 0;
      compat_seen <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.compat = m_tdata[0];
        got.ratio  = m_tdata[RATIO_BITS:1];
        got.undef  = m_tdata[RATIO_BITS+1];
        results     <= results + 1;
        undef_seen  <= undef_seen + got.undef;
        compat_seen <= compat_seen + got.compat;
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("ERROR: result with nothing expected: %h", m_tdata);
          errors <= errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.compat !== exp_r.compat || got.ratio !== exp_r.ratio ||
              got.undef !== exp_r.undef) begin
            if (errors < 10)
              $display("ERROR: result %0d expected compat=%b ratio=%h undef=%b, got %b %h %b",
                       results, exp_r.compat, exp_r.ratio, exp_r.undef,
                       got.compat, got.ratio, got.undef);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) expected_q.push_back(predict_ratio(s_tdata));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RATIO_MIN) win_min = longint'($signed(cfg_data));
        else if (cfg_index == CFG_RATIO_MAX) win_max = longint'($signed(cfg_data));
      end
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-hit angle ratio check testbench
// Drives directed and random hit quadruples through several ratio windows with
// random bursts and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import fhar_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int   errors, pending, results, undef_seen, compat_seen;
  int   items_sent;
  int   burst_left;
  bit   hold_req;
  bit   no_gaps;
  int   idle_cycles;

  four_hit_angle_ratio_check u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fhar_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results(results),
    .undef_seen(undef_seen), .compat_seen(compat_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", pending);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall pattern is redrawn at random from four modes; a long hold on request.
  initial begin
    int mode;
    int cyc;
    m_tready = 1'b0;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      if (cyc % 150 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0: m_tready = 1'b1;
        1: m_tready = ($urandom_range(0, 9) < 7);
        2: m_tready = (cyc % 3 == 0);
        default: m_tready = ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  function automatic logic [IN_TDATA_BITS-1:0] pack_hits(int c [12]);
    logic [IN_TDATA_BITS-1:0] d;
    d = '0;
    for (int k = 0; k < 12; k++) d[k*COORD_BITS +: COORD_BITS] = c[k][COORD_BITS-1:0];
    return d;
  endfunction

  function automatic logic [IN_TDATA_BITS-1:0] random_hits();
    logic [IN_TDATA_BITS-1:0] d;
    for (int k = 0; k < IN_TDATA_BITS / 32; k++) d[k*32 +: 32] = $urandom;
    return d;
  endfunction

  // Points along a gently bending track, sometimes with a kink or a repeat.
  function automatic logic [IN_TDATA_BITS-1:0] track_hits();
    int c [12];
    int p [3], dir [3], bend [3];
    int span;
    span = 1 << $urandom_range(4, 16);
    for (int k = 0; k < 3; k++) begin
      p[k]    = $urandom_range(0, 1 << 21) - (1 << 20);
      dir[k]  = $urandom_range(0, 2 * span) - span;
      bend[k] = $urandom_range(0, span / 8 + 1) - span / 16;
    end
    for (int h = 0; h < 4; h++)
      for (int k = 0; k < 3; k++)
        c[h*3+k] = p[k] + h * dir[k] + h * h * bend[k] + $urandom_range(0, 2) - 1;
    case ($urandom_range(0, 9))
      0: for (int k = 0; k < 3; k++) c[3+k] = c[k];
      1: for (int k = 0; k < 3; k++) c[9+k] = c[6+k];
      2: for (int k = 0; k < 3; k++) c[9+k] = c[6+k] - dir[k];
      3: for (int k = 0; k < 3; k++) c[9+k] = c[6+k] + dir[k];
      default: ;
    endcase
    return pack_hits(c);
  endfunction

  task automatic send_item(logic [IN_TDATA_BITS-1:0] d);
    s_tdata  = d;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !no_gaps) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) send_item(track_hits());
      else send_item(random_hits());
    end
  endtask

  task automatic directed_items();
    int c [12];
    int lo, hi;
    lo = -(1 << 23);
    hi = (1 << 23) - 1;
    c = '{default: 0};
    send_item(pack_hits(c));
    c = '{0, 0, 0, 100, 0, 0, 200, 0, 0, 300, 0, 0};
    send_item(pack_hits(c));
    c = '{0, 0, 0, 100, 0, 0, 200, 50, 0, 300, 100, 0};
    send_item(pack_hits(c));
    c = '{0, 0, 0, 100, 0, 0, 200, 0, 0, 200, 100, 0};
    send_item(pack_hits(c));
    c = '{0, 0, 0, 100, 0, 0, 0, 0, 0, 100, 0, 0};
    send_item(pack_hits(c));
    c = '{5, 5, 5, 5, 5, 5, 80, 9, 1, 30, -40, 7};
    send_item(pack_hits(c));
    c = '{0, 0, 0, 100, 0, 0, 200, 3, 0, 200, 3, 0};
    send_item(pack_hits(c));
    c = '{lo, lo, lo, hi, hi, hi, lo, lo, lo, hi, hi, hi};
    send_item(pack_hits(c));
    c = '{hi, lo, hi, lo, hi, lo, hi, hi, lo, lo, lo, hi};
    send_item(pack_hits(c));
    c = '{lo, 0, 0, hi, 0, 0, hi, hi, 0, hi, hi, hi};
    send_item(pack_hits(c));
    c = '{hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi};
    send_item(pack_hits(c));
    c = '{0, 0, 0, 1, 0, 0, 1, 1, 0, 1, 1, 1};
    send_item(pack_hits(c));
    c = '{0, 0, 0, 1000, 0, 0, 2000, 1, 0, 3000, 0, 0};
    send_item(pack_hits(c));
    c = '{0, 0, 0, 1000, 0, 0, 2000, 0, 1, 2000, 1000, 1};
    send_item(pack_hits(c));
    c = '{0, 0, 0, 0, 1000, 0, -1, 0, 0, -1, 0, 0};
    send_item(pack_hits(c));
    c = '{lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo};
    send_item(pack_hits(c));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RATIO_MIN;
    cfg_data = '0;
    hold_req = 1'b0;
    no_gaps = 1'b0;
    items_sent = 0;
    burst_left = 5;
    idle_cycles = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    directed_items();
    random_items(250);
    drain();

    write_reg(CFG_RATIO_MIN, 32'h8000_0000);
    write_reg(CFG_RATIO_MAX, 32'h7FFF_FFFF);
    directed_items();
    // Long output hold while the input keeps offering items back to back.
    no_gaps = 1'b1;
    hold_req = 1'b1;
    random_items(250);
    no_gaps = 1'b0;
    drain();

    write_reg(CFG_RATIO_MIN, 32'h0000_8000);
    write_reg(CFG_RATIO_MAX, 32'h0002_0000);
    random_items(300);
    drain();

    write_reg(CFG_RATIO_MIN, 32'h0001_0000);
    write_reg(CFG_RATIO_MAX, 32'h0001_0000);
    random_items(250);
    drain();

    write_reg(CFG_RATIO_MIN, 32'h7FFF_FFFF);
    write_reg(CFG_RATIO_MAX, 32'h8000_0000);
    directed_items();
    random_items(250);
    drain();

    write_reg(CFG_RATIO_MIN, 32'h7FFF_FFFF);
    write_reg(CFG_RATIO_MAX, 32'h7FFF_FFFF);
    random_items(250);
    drain();
    repeat (120) @(negedge clk);

    $display("Sent %0d hit quadruples over six ratio windows; %0d results checked,",
             items_sent, results);
    $display("%0d inside the window and %0d with an undefined ratio.",
             compat_seen, undef_seen);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing.", errors, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/fhar_pkg.sv
rtl/core/fhar_angle.sv
rtl/core/fhar_div.sv
rtl/core/four_hit_angle_ratio_check.sv
rtl/core/fhar_check.sv
sim/fhar_checker.sv
sim/tb_top.sv
